FILE: rtl/core/af_sm_pkg.sv
// shared constants, types and sha-256 tables for the af split/merge block
// no dependencies
`default_nettype none
package af_sm_pkg;

  localparam int MAX_STRIPE_BYTES = 1024;
  localparam int SECTION_BYTES    = 32;
  localparam int POS_W   = $clog2(MAX_STRIPE_BYTES);
  localparam int NB_W    = 11;
  localparam int NS_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_COUNT = 2'd1;

  localparam logic [NB_W-1:0] STRIPE_BYTES_RST = 11'd32;
  localparam logic [NS_W-1:0] STRIPE_COUNT_RST = 16'd4000;

  typedef logic [15:0][31:0] blk_t;
  typedef logic [7:0][31:0]  dig_t;

  localparam logic [31:0] SHA_H0 [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage
`default_nettype wire

FILE: rtl/core/af_sm_if.sv
// valid/ready channel interfaces: byte input, byte result, config write
// depends on af_sm_pkg
`default_nettype none
interface af_sm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface af_sm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

interface af_sm_cfg_if;
  import af_sm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/af_split_merge_sha256.sv
// anti-forensic split/merge with sha-256 diffusion, top level
// depends on af_sm_pkg, af_sm_if, af_sm_ram, af_sm_sha256
// a result word is registered and offered on the output in the cycle after its input word is accepted
// each word passes the load state before the next is taken; a section finished
//   before the final stripe starts the shared sha-256 round unit, then writes back its chain bytes
// reset: synchronous, active low; registers to defaults, positions to zero;
//   the chain memory needs no clearing, it is only read after stripe zero
`default_nettype none
module af_split_merge_sha256
  import af_sm_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst_n,
  af_sm_in_if.sink    in_if,
  af_sm_out_if.source out_if,
  af_sm_cfg_if.sink   cfg_if
);
  localparam logic [2:0] ST_LOAD  = 3'd0;  // present chain address
  localparam logic [2:0] ST_IDLE  = 3'd1;  // wait for a word
  localparam logic [2:0] ST_START = 3'd2;  // kick the hash unit
  localparam logic [2:0] ST_HASH  = 3'd3;  // rounds running
  localparam logic [2:0] ST_WB    = 3'd4;  // digest bytes into the chain

  logic [2:0]      state_r, state_nxt;
  logic [NB_W-1:0] sb_r, sb_nxt;
  logic [NS_W-1:0] sc_r, sc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [NS_W-1:0]  stripe_r, stripe_nxt;
  logic [POS_W-1:0] base_r, base_nxt;
  logic [5:0]       len_r, len_nxt;
  logic [4:0]       wb_i_r, wb_i_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r;
  logic             ol_r;
  logic [7:0]       sec_r [SECTION_BYTES];

  // effective geometry: zero means one, length saturates at the chain size
  logic [NB_W-1:0] nb_eff;
  logic [NS_W-1:0] ns_eff;
  logic            stripe_end, final_stripe, accept, cfg_wr;
  logic [7:0]      chain_b, xb;

  logic            ram_we;
  logic [POS_W-1:0] ram_waddr;
  logic [7:0]      ram_wdata, ram_q;

  logic            sha_done;
  dig_t            sha_dig;
  blk_t            blk;
  logic [7:0]      blkb [64];
  logic [31:0]     sec_idx;
  logic [9:0]      bitlen;
  logic [31:0]     dword;

  always_comb begin
    if (sb_r == '0) nb_eff = NB_W'(1);
    else if (sb_r > NB_W'(MAX_STRIPE_BYTES)) nb_eff = NB_W'(MAX_STRIPE_BYTES);
    else nb_eff = sb_r;
    ns_eff = (sc_r == '0) ? NS_W'(1) : sc_r;
  end

  assign stripe_end   = (NB_W'(pos_r) + NB_W'(1)) >= nb_eff;
  assign final_stripe = ({1'b0, stripe_r} + 17'd1) >= {1'b0, ns_eff};

  // the chain is all zero throughout stripe zero, written in full after it
  assign chain_b = (stripe_r == '0) ? 8'h00 : ram_q;
  assign xb      = chain_b ^ in_if.data_byte;

  assign in_if.ready  = (state_r == ST_IDLE) && (!ov_r || out_if.ready);
  assign accept       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid &&
                        (cfg_if.index == CFG_STRIPE_BYTES ||
                         cfg_if.index == CFG_STRIPE_COUNT);

  // hash block: big-endian section index, section bytes, padding, bit length
  always_comb begin
    sec_idx = 32'(base_r) >> 5;
    bitlen  = {len_r + 7'd4, 3'b000};
    for (int j = 0; j < 64; j++) blkb[j] = 8'h00;
    blkb[0] = sec_idx[31:24];
    blkb[1] = sec_idx[23:16];
    blkb[2] = sec_idx[15:8];
    blkb[3] = sec_idx[7:0];
    for (int k = 0; k < SECTION_BYTES; k++) begin
      if (6'(k) < len_r) blkb[4+k] = sec_r[k];
      else if (6'(k) == len_r) blkb[4+k] = 8'h80;
      else blkb[4+k] = 8'h00;
    end
    blkb[36] = (len_r == 6'd32) ? 8'h80 : 8'h00;
    blkb[62] = {6'b0, bitlen[9:8]};
    blkb[63] = bitlen[7:0];
    for (int w = 0; w < 16; w++)
      blk[w] = {blkb[4*w], blkb[4*w+1], blkb[4*w+2], blkb[4*w+3]};
  end

  // digest byte for write-back
  assign dword     = sha_dig[wb_i_r[4:2]];
  assign ram_we    = (state_r == ST_WB);
  assign ram_waddr = base_r + POS_W'(wb_i_r);
  always_comb begin
    case (wb_i_r[1:0])
      2'd0:    ram_wdata = dword[31:24];
      2'd1:    ram_wdata = dword[23:16];
      2'd2:    ram_wdata = dword[15:8];
      default: ram_wdata = dword[7:0];
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    sb_nxt     = sb_r;
    sc_nxt     = sc_r;
    pos_nxt    = pos_r;
    stripe_nxt = stripe_r;
    base_nxt   = base_r;
    len_nxt    = len_r;
    wb_i_nxt   = wb_i_r;
    ov_nxt     = ov_r;
    if (ov_r && out_if.ready) ov_nxt = 1'b0;
    case (state_r)
      ST_LOAD: state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOAD;
          if (final_stripe) begin
            ov_nxt = 1'b1;
            if (stripe_end) begin
              pos_nxt    = '0;
              stripe_nxt = '0;
            end else begin
              pos_nxt = pos_r + POS_W'(1);
            end
          end else begin
            if (pos_r[4:0] == 5'd31 || stripe_end) begin
              state_nxt = ST_START;
              base_nxt  = pos_r & ~POS_W'(SECTION_BYTES - 1);
              len_nxt   = {1'b0, pos_r[4:0]} + 6'd1;
            end
            if (stripe_end) begin
              pos_nxt    = '0;
              stripe_nxt = stripe_r + NS_W'(1);
            end else begin
              pos_nxt = pos_r + POS_W'(1);
            end
          end
        end
      end
      ST_START: state_nxt = ST_HASH;
      ST_HASH: begin
        if (sha_done) begin
          state_nxt = ST_WB;
          wb_i_nxt  = '0;
        end
      end
      ST_WB: begin
        wb_i_nxt = wb_i_r + 5'd1;
        if ({1'b0, wb_i_r} == len_r - 6'd1) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
    // a write to either register aborts any run and starts over with a clear chain
    if (cfg_wr) begin
      if (cfg_if.index == CFG_STRIPE_BYTES) sb_nxt = cfg_if.data[NB_W-1:0];
      else sc_nxt = cfg_if.data[NS_W-1:0];
      pos_nxt    = '0;
      stripe_nxt = '0;
      state_nxt  = ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      sb_r     <= STRIPE_BYTES_RST;
      sc_r     <= STRIPE_COUNT_RST;
      pos_r    <= '0;
      stripe_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sb_r     <= sb_nxt;
      sc_r     <= sc_nxt;
      pos_r    <= pos_nxt;
      stripe_r <= stripe_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    len_r  <= len_nxt;
    wb_i_r <= wb_i_nxt;
    if (accept && !final_stripe) sec_r[pos_r[4:0]] <= xb;
    if (accept && final_stripe) begin
      ob_r <= xb;
      ol_r <= stripe_end;
    end
  end

  assign out_if.valid    = ov_r;
  assign out_if.out_byte = ob_r;
  assign out_if.out_last = ol_r;

  af_sm_ram #(.WIDTH(8), .DEPTH(MAX_STRIPE_BYTES)) u_chain (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos_r),
    .rdata (ram_q)
  );

  af_sm_sha256 u_sha (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == ST_START),
    .blk    (blk),
    .done   (sha_done),
    .digest (sha_dig)
  );

  // words are only taken while waiting in idle
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  // write-back never runs past the section
  a_wb_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WB |-> {1'b0, wb_i_r} < len_r) else $error("write-back overrun");
  // byte position stays inside the stripe
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    NB_W'(pos_r) < nb_eff) else $error("position beyond stripe");
  // a section start always follows a word taken in idle
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_START |-> $past(accept)) else $error("hash start without word");
endmodule
`default_nettype wire

FILE: rtl/core/af_sm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module af_sm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/af_sm_sha256.sv
// iterative sha-256 compression of one block, one round per cycle
// depends on af_sm_pkg
`default_nettype none
module af_sm_sha256
  import af_sm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire blk_t blk,
  output logic      done,
  output dig_t      digest
);
  logic       busy_r, busy_nxt;
  logic       fin_r, fin_nxt;
  logic       done_r, done_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  dig_t        dig_r;

  logic [31:0] s1e, chv, t1, s0a, mjv, t2, ws0, ws1, wnew;

  always_comb begin
    s1e  = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]} ^
           {v_r[4][24:0], v_r[4][31:25]};
    chv  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + s1e + chv + SHA_K[rnd_r] + w_r[0];
    s0a  = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]} ^
           {v_r[0][21:0], v_r[0][31:22]};
    mjv  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = s0a + mjv;
    ws0  = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^
           (w_r[1] >> 3);
    ws1  = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]} ^
           (w_r[14] >> 10);
    wnew = w_r[0] + ws0 + w_r[9] + ws1;
  end

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    rnd_nxt  = rnd_r;
    if (start) begin
      busy_nxt = 1'b1;
      rnd_nxt  = '0;
    end else if (busy_r) begin
      rnd_nxt = rnd_r + 6'd1;
      if (rnd_r == 6'd63) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      rnd_r  <= rnd_nxt;
    end
  end

  // working state and message schedule
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= SHA_H0[i];
      for (int i = 0; i < 16; i++) w_r[i] <= blk[i];
    end else if (busy_r) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
    end else if (fin_r) begin
      for (int i = 0; i < 8; i++) dig_r[i] <= SHA_H0[i] + v_r[i];
    end
  end

  assign done   = done_r;
  assign digest = dig_r;
endmodule
`default_nettype wire

FILE: sim/af_sm_checker.sv
// checker for af_split_merge_sha256: watches the byte, result and config channels,
// predicts each result word with its own sha-256 chain model and compares in order
// depends on af_sm_pkg and af_sm_if
`timescale 1ns / 100ps
module af_sm_checker
  import af_sm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  af_sm_in_if.sink        in_mon,
  af_sm_out_if.sink       out_mon,
  af_sm_cfg_if.sink       cfg_mon,
  output int              fail_count,
  output int              pending_words,
  output int              result_words,
  output int              byte_words
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } result_t;

  result_t        expected_q[$];
  logic [NB_W-1:0] cur_bytes;
  logic [NS_W-1:0] cur_count;
  logic [7:0]     chain [MAX_STRIPE_BYTES];
  logic [7:0]     section [SECTION_BYTES];
  logic [31:0]    digest [8];
  int             pos_q;
  int             stripe_q;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one-block sha-256 over the big-endian section index and len section bytes
  task automatic hash_section(int idx, int len);
    logic [7:0]  blk [64];
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int          bits;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    blk[0] = idx[31:24]; blk[1] = idx[23:16]; blk[2] = idx[15:8]; blk[3] = idx[7:0];
    for (int i = 0; i < len; i++) blk[4 + i] = section[i];
    blk[4 + len] = 8'h80;
    bits = (4 + len) * 8;
    blk[62] = bits[15:8];
    blk[63] = bits[7:0];
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = SHA_H0[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) digest[i] = SHA_H0[i] + v[i];
  endtask

  task automatic clear_run();
    for (int i = 0; i < MAX_STRIPE_BYTES; i++) chain[i] = 8'h00;
    pos_q = 0;
    stripe_q = 0;
  endtask

  // advance the chain model by one byte, queue a result on the last stripe
  task automatic predict_byte(logic [7:0] d);
    int      nb, ns, base, len;
    logic    stripe_end;
    result_t r;
    nb = (cur_bytes == 0) ? 1 : (cur_bytes > MAX_STRIPE_BYTES) ? MAX_STRIPE_BYTES
                                                                 : int'(cur_bytes);
    ns = (cur_count == 0) ? 1 : int'(cur_count);
    stripe_end = (pos_q + 1 >= nb);
    if (pos_q >= MAX_STRIPE_BYTES) pos_q = MAX_STRIPE_BYTES - 1;
    if (stripe_q + 1 < ns) begin
      section[pos_q % SECTION_BYTES] = chain[pos_q] ^ d;
      if ((pos_q % SECTION_BYTES) == SECTION_BYTES - 1 || stripe_end) begin
        base = pos_q - (pos_q % SECTION_BYTES);
        len  = pos_q - base + 1;
        hash_section(base / SECTION_BYTES, len);
        for (int i = 0; i < len; i++)
          chain[base + i] = 8'(digest[i >> 2] >> (24 - 8 * (i & 3)));
      end
      if (stripe_end) begin
        pos_q = 0;
        stripe_q++;
      end else begin
        pos_q++;
      end
    end else begin
      r.out_byte = d ^ chain[pos_q];
      r.out_last = stripe_end;
      expected_q.push_back(r);
      if (stripe_end) clear_run();
      else pos_q++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      cur_bytes <= STRIPE_BYTES_RST;
      cur_count <= STRIPE_COUNT_RST;
      clear_run();
      expected_q.delete();
      fail_count <= 0;
      result_words <= 0;
      byte_words <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        result_words <= result_words + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word: byte %02h last %0b",
                     out_mon.out_byte, out_mon.out_last);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.out_byte !== out_mon.out_byte || e.out_last !== out_mon.out_last) begin
            if (fail_count < 10)
              $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       e.out_byte, e.out_last, out_mon.out_byte, out_mon.out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        byte_words <= byte_words + 1;
        predict_byte(in_mon.data_byte);
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_STRIPE_BYTES) begin
          cur_bytes <= cfg_mon.data[NB_W-1:0];
          clear_run();
        end else if (cfg_mon.index == CFG_STRIPE_COUNT) begin
          cur_count <= cfg_mon.data[NS_W-1:0];
          clear_run();
        end
      end
    end
    pending_words = expected_q.size();
  end

endmodule

FILE: sim/af_split_merge_sha256_tb.sv
// stimulus top for af_split_merge_sha256: drives byte stripes and config writes
// through idle/stall phases; the checker module does prediction and comparison
// depends on af_sm_pkg, af_sm_if, af_sm_checker and the block rtl
`timescale 1ns / 100ps
module af_split_merge_sha256_tb;
  import af_sm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TARGET_BYTES   = 1950;

  // indexes past the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  af_sm_in_if  in_ch ();
  af_sm_out_if out_ch ();
  af_sm_cfg_if cfg_ch ();

  int fail_count, pending_words, result_words, byte_words;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;       // long receiver stall to fill the block
  bit held;
  bit timed_out;
  int idle_cycles;
  int runs_done;

  always #5 clk = ~clk;

  af_split_merge_sha256 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source),
    .cfg_if (cfg_ch.sink)
  );

  af_sm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch.sink),
    .out_mon       (out_ch.sink),
    .cfg_mon       (cfg_ch.sink),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .result_words  (result_words),
    .byte_words    (byte_words)
  );

  // receiver: random stall at the falling edge, forced low during a hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: cycles in which no word moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out <= 1'b1;
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // hand one byte to the block, with a random idle gap before it
  // valid stays up after the accept; an idle gap or drain drops it
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait for every expected word, then let a finishing hash drain
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one full run of count stripes of nbytes bytes
  task automatic send_run(int nbytes, int count, bit ramp);
    for (int s = 0; s < count; s++)
      for (int i = 0; i < nbytes; i++)
        send_byte(ramp ? 8'(s * 4 + i) : 8'($urandom_range(255)));
    runs_done++;
  endtask

  task automatic set_shape(int nbytes, int count);
    write_reg(CFG_STRIPE_BYTES, CFG_DATA_W'(nbytes));
    write_reg(CFG_STRIPE_COUNT, CFG_DATA_W'(count));
  endtask

  initial begin
    int nb, nc;
    bit do_hold;
    in_ch.valid = 1'b0; in_ch.data_byte = 8'h00;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_STRIPE_BYTES; cfg_ch.data = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 1'b0; held = 1'b0; runs_done = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: single stripe passes bytes through, extremes of the byte
    set_shape(4, 1);
    send_byte(8'h00); send_byte(8'hff); send_byte(8'h55); send_byte(8'haa);
    // zero length and zero count behave as one
    set_shape(0, 0);
    send_byte(8'h81); send_byte(8'h7e);
    // length above the maximum saturates; config write mid-run aborts it
    write_reg(CFG_STRIPE_BYTES, 16'h07ff);
    send_byte(8'h12); send_byte(8'h34);
    // unknown register indexes are ignored
    write_reg(CFG_SPARE_A, 16'h0003);
    write_reg(CFG_SPARE_B, 16'hffff);
    // two stripes with a partial trailing section, and a 33-byte stripe
    set_shape(5, 2);
    send_run(5, 2, 1'b1);
    write_reg(CFG_STRIPE_BYTES, 16'd33);
    send_byte(8'hf0);
    write_reg(CFG_STRIPE_COUNT, 16'hffff);  // largest count, aborted below

    // random runs through the idle/stall phases
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 38 : 61) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 38 : 61) : 0;
      while (byte_words < (phase + 1) * (TARGET_BYTES - MAX_STRIPE_BYTES) / 4) begin
        case ($urandom_range(5))
          0: nb = $urandom_range(1, 8);
          1: nb = 32;
          2: nb = $urandom_range(33, 70);
          default: nb = $urandom_range(1, 40);
        endcase
        nc = $urandom_range(1, 4);
        do_hold = (phase == 0 && !held);
        // single stripe during the hold-off so every byte makes a result word
        if (do_hold) nc = 1;
        set_shape(nb, nc);
        if (do_hold) begin
          held = 1'b1;
          // long receiver hold-off while the sender keeps offering bytes
          fork
            begin
              hold_off = 1'b1;
              repeat (300) @(negedge clk);
              hold_off = 1'b0;
            end
            send_run(nb, nc, 1'b0);
          join
        end else begin
          send_run(nb, nc, 1'b0);
        end
        // sometimes a second run with the same shape, back to back
        if ($urandom_range(2) == 0) send_run(nb, nc, 1'b0);
      end
    end
    // largest stripe once, single stripe
    set_shape(MAX_STRIPE_BYTES, 1);
    send_run(MAX_STRIPE_BYTES, 1, 1'b0);

    drain();
    $display("covered %0d runs, %0d input words, %0d result words",
             runs_done, byte_words, result_words);
    $display("stripe lengths 0..2047 written, counts 0..65535, four idle/stall phases");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: af_split_merge_sha256.f
rtl/core/af_sm_pkg.sv
rtl/core/af_sm_if.sv
rtl/core/af_sm_ram.sv
rtl/core/af_sm_sha256.sv
rtl/core/af_split_merge_sha256.sv
sim/af_sm_checker.sv
sim/af_split_merge_sha256_tb.sv
